FILE: hdl/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg
// Shared types, character codes and register indexes of the heading field parser.
// ----------------------------------------------------------------------------
package shp_pkg;

  // default width of the reported value
  localparam int unsigned ValueWidthDefault = 32;

  // configuration registers
  localparam int unsigned CountWidth    = 4;
  localparam int unsigned CfgIndexWidth = 1;

  typedef logic [CfgIndexWidth-1:0] cfg_index_t;
  typedef logic [CountWidth-1:0]    count_t;

  localparam cfg_index_t CfgCommaCount = 1'b0;
  localparam cfg_index_t CfgSkipCount  = 1'b1;

  localparam count_t CommaCountReset = 4'd3;
  localparam count_t SkipCountReset  = 4'd4;

  typedef struct packed {
    count_t comma_count;
    count_t skip_count;
  } cfg_t;

  // ascii codes
  localparam logic [7:0] CharComma    = 8'h2C;
  localparam logic [7:0] CharCr       = 8'h0D;
  localparam logic [7:0] CharMinus    = 8'h2D;
  localparam logic [7:0] CharPoint    = 8'h2E;
  localparam logic [7:0] CharZero     = 8'h30;
  localparam logic [7:0] CharNine     = 8'h39;
  localparam logic [7:0] CharTagFirst = 8'h4D;

  localparam int unsigned TagPosWidth = 2;
  typedef logic [TagPosWidth-1:0] tag_pos_t;
  localparam tag_pos_t TagPosLast = 2'd3;

  // letters of the tag "Magx"
  function automatic logic [7:0] tag_char(input tag_pos_t pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h4D;
      2'd1:    c = 8'h61;
      2'd2:    c = 8'h67;
      default: c = 8'h78;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/shp_if.sv
// ----------------------------------------------------------------------------
// shp channel interfaces
// Valid/ready channels for input bytes, parsed results and register writes.
// ----------------------------------------------------------------------------
interface shp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface shp_result_if #(
  parameter int unsigned ValueWidth = shp_pkg::ValueWidthDefault
);
  logic                         valid;
  logic                         ready;
  logic signed [ValueWidth-1:0] heading_hundredths;
  logic                         well_formed;
  logic                         saturated;

  modport source (output valid, output heading_hundredths, output well_formed,
                  output saturated, input ready);
  modport sink   (input valid, input heading_hundredths, input well_formed,
                  input saturated, output ready);
endinterface

interface shp_cfg_if;
  logic                 valid;
  logic                 ready;
  shp_pkg::cfg_index_t  reg_index;
  shp_pkg::count_t      wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: hdl/sensor_heading_field_parser_core.sv
// ----------------------------------------------------------------------------
// sensor_heading_field_parser_core
// Parses a signed decimal heading field out of a sensor's ascii byte stream.
// ----------------------------------------------------------------------------
// usage
//   data_i   : one ascii character per transaction from the receiver
//   result_o : one transaction per carriage return that closes a field:
//              value in hundredths (saturated), well-formed and saturated flags
//   cfg_i    : register writes, index 0 comma_count, index 1 skip_count;
//              always ready, write only while no byte is in flight
// the block hunts for the tag "Magx", passes comma_count commas, skips
// skip_count characters and then accumulates the field up to the carriage
// return
// throughput is one byte per cycle while result_o is not stalled: every byte passes an
// input register and the parsing logic into the state and the result register
// a carriage return that closes a field reaches result_o.valid through the input register and the result register
// when the receiver stalls, the result register holds; bytes that produce no
// result keep flowing, and the input register holds the next carriage return
// until the result is taken
// reset clears the registers to comma_count 3 and skip_count 4, empties both
// register stages and restarts the tag hunt
// ----------------------------------------------------------------------------
module sensor_heading_field_parser_core #(
  parameter int unsigned ValueWidth = shp_pkg::ValueWidthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  shp_byte_if.sink     data_i,
  shp_cfg_if.sink      cfg_i,
  shp_result_if.source result_o
);

  // configuration registers
  shp_pkg::cfg_t cfg_q, cfg_d;

  // input stage to parser
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       byte_take;

  // register writes are always taken
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        shp_pkg::CfgCommaCount: cfg_d.comma_count = cfg_i.wdata;
        shp_pkg::CfgSkipCount:  cfg_d.skip_count  = cfg_i.wdata;
        default:                cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.comma_count <= shp_pkg::CommaCountReset;
      cfg_q.skip_count  <= shp_pkg::SkipCountReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // byte capture
  shp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .data_i  (data_i),
    .take_i  (byte_take),
    .valid_o (byte_valid),
    .byte_o  (byte_data)
  );

  // parsing state and result register
  shp_parser #(
    .ValueWidth (ValueWidth)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .byte_valid_i (byte_valid),
    .byte_i       (byte_data),
    .take_o       (byte_take),
    .result_o     (result_o)
  );

endmodule

FILE: hdl/shp_in_reg.sv
// ----------------------------------------------------------------------------
// shp_in_reg
// Input register stage: captures one byte per transaction for the parser.
// ----------------------------------------------------------------------------
module shp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  shp_byte_if.sink   data_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  assign data_i.ready = !valid_q || take_i;
  assign accept       = data_i.valid && data_i.ready;

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_i.data_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

FILE: hdl/shp_parser.sv
// ----------------------------------------------------------------------------
// shp_parser
// Tag hunt, comma count, skip and decimal field accumulation, result register.
// ----------------------------------------------------------------------------
module shp_parser #(
  parameter int unsigned ValueWidth = shp_pkg::ValueWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  shp_pkg::cfg_t cfg_i,
  input  logic          byte_valid_i,
  input  logic [7:0]    byte_i,
  output logic          take_o,
  shp_result_if.source  result_o
);

  localparam int unsigned IntWidth = ValueWidth - 6;
  localparam int unsigned MulWidth = IntWidth + 4;
  localparam int unsigned MagWidth = ValueWidth + 1;

  localparam logic [MagWidth-1:0] NegLimit = MagWidth'(1) << (ValueWidth - 1);
  localparam logic [MagWidth-1:0] PosLimit = NegLimit - MagWidth'(1);
  localparam logic [IntWidth-1:0] IntCap   =
    IntWidth'(NegLimit / MagWidth'(100) + MagWidth'(1));

  typedef enum logic [1:0] {
    PhHunt,
    PhCommas,
    PhSkip,
    PhField
  } phase_e;

  phase_e                phase_q, phase_d;
  shp_pkg::tag_pos_t     tag_pos_q, tag_pos_d;
  shp_pkg::count_t       commas_left_q, commas_left_d;
  shp_pkg::count_t       skip_left_q, skip_left_d;
  logic                  neg_q, neg_d;
  logic                  point_q, point_d;
  logic                  bad_q, bad_d;
  logic                  started_q, started_d;
  logic [IntWidth-1:0]   int_q, int_d;
  logic [6:0]            frac_q, frac_d;
  logic [1:0]            frac_digits_q, frac_digits_d;
  logic                  ovf_q, ovf_d;

  logic                  out_valid_q, out_valid_d;
  logic [ValueWidth-1:0] heading_q, heading_d;
  logic                  well_q, well_d;
  logic                  sat_q, sat_d;

  logic                  is_cr, is_digit, produce, out_free, take;
  logic [3:0]            digit;
  logic [MulWidth-1:0]   int_mul;
  logic                  int_hit;
  logic [6:0]            frac_full;
  logic [MagWidth-1:0]   mag, mag_clamped;
  logic                  clamp;
  logic                  open_field, open_skip;

  assign is_cr    = (byte_i == shp_pkg::CharCr);
  assign is_digit = (byte_i >= shp_pkg::CharZero) && (byte_i <= shp_pkg::CharNine);
  assign digit    = byte_i[3:0];
  assign produce  = byte_valid_i && (phase_q == PhField) && is_cr;
  assign out_free = !out_valid_q || result_o.ready;
  assign take     = byte_valid_i && (!produce || out_free);
  assign take_o   = take;

  // integer digit accumulate, compared against the cap
  assign int_mul = MulWidth'(int_q) * MulWidth'(10) + MulWidth'(digit);
  assign int_hit = int_mul >= MulWidth'(IntCap);

  // fraction scaled to hundredths
  always_comb begin
    case (frac_digits_q)
      2'd0:    frac_full = 7'd0;
      2'd1:    frac_full = frac_q * 7'd10;
      default: frac_full = frac_q;
    endcase
  end

  assign mag = MagWidth'(int_q) * MagWidth'(100) + MagWidth'(frac_full);

  // finished value with clamping
  always_comb begin
    clamp       = 1'b0;
    mag_clamped = mag;
    if (neg_q) begin
      if (ovf_q || (mag > NegLimit)) begin
        clamp       = 1'b1;
        mag_clamped = NegLimit;
      end
    end else begin
      if (ovf_q || (mag > PosLimit)) begin
        clamp       = 1'b1;
        mag_clamped = PosLimit;
      end
    end
    if (bad_q) begin
      heading_d = '0;
      well_d    = 1'b0;
      sat_d     = 1'b0;
    end else begin
      heading_d = neg_q ? ValueWidth'(MagWidth'(0) - mag_clamped)
                        : ValueWidth'(mag_clamped);
      well_d    = 1'b1;
      sat_d     = clamp;
    end
  end

  always_comb begin
    if (produce && take) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // next state
  always_comb begin
    phase_d       = phase_q;
    tag_pos_d     = tag_pos_q;
    commas_left_d = commas_left_q;
    skip_left_d   = skip_left_q;
    neg_d         = neg_q;
    point_d       = point_q;
    bad_d         = bad_q;
    started_d     = started_q;
    int_d         = int_q;
    frac_d        = frac_q;
    frac_digits_d = frac_digits_q;
    ovf_d         = ovf_q;
    open_field    = 1'b0;
    open_skip     = 1'b0;
    if (take) begin
      case (phase_q)
        PhHunt: begin
          if (byte_i == shp_pkg::tag_char(tag_pos_q)) begin
            if (tag_pos_q == shp_pkg::TagPosLast) begin
              tag_pos_d = '0;
              if (cfg_i.comma_count != '0) begin
                phase_d       = PhCommas;
                commas_left_d = cfg_i.comma_count;
              end else begin
                open_skip = 1'b1;
              end
            end else begin
              tag_pos_d = tag_pos_q + shp_pkg::tag_pos_t'(1);
            end
          end else begin
            tag_pos_d = (byte_i == shp_pkg::CharTagFirst) ? shp_pkg::tag_pos_t'(1) : '0;
          end
        end
        PhCommas: begin
          if (byte_i == shp_pkg::CharComma) begin
            commas_left_d = commas_left_q - shp_pkg::count_t'(1);
            if (commas_left_q == shp_pkg::count_t'(1)) begin
              open_skip = 1'b1;
            end
          end
        end
        PhSkip: begin
          skip_left_d = skip_left_q - shp_pkg::count_t'(1);
          if (skip_left_q == shp_pkg::count_t'(1)) begin
            open_field = 1'b1;
          end
        end
        PhField: begin
          if (is_cr) begin
            phase_d   = PhHunt;
            tag_pos_d = '0;
          end else begin
            if (!bad_q) begin
              if ((byte_i == shp_pkg::CharMinus) && !started_q) begin
                neg_d = 1'b1;
              end else if ((byte_i == shp_pkg::CharPoint) && !point_q) begin
                point_d = 1'b1;
              end else if (is_digit) begin
                if (point_q) begin
                  if (frac_digits_q < 2'd2) begin
                    frac_d        = frac_q * 7'd10 + 7'(digit);
                    frac_digits_d = frac_digits_q + 2'd1;
                  end
                end else if (int_q >= IntCap) begin
                  ovf_d = 1'b1;
                end else if (int_hit) begin
                  int_d = IntCap;
                  ovf_d = 1'b1;
                end else begin
                  int_d = IntWidth'(int_mul);
                end
              end else begin
                bad_d = 1'b1;
              end
            end
            started_d = 1'b1;
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
      // zero skip count falls straight through to the field
      if (open_skip) begin
        if (cfg_i.skip_count != '0) begin
          phase_d     = PhSkip;
          skip_left_d = cfg_i.skip_count;
        end else begin
          open_field = 1'b1;
        end
      end
      if (open_field) begin
        phase_d       = PhField;
        neg_d         = 1'b0;
        point_d       = 1'b0;
        bad_d         = 1'b0;
        started_d     = 1'b0;
        int_d         = '0;
        frac_d        = '0;
        frac_digits_d = '0;
        ovf_d         = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhHunt;
      tag_pos_q     <= '0;
      commas_left_q <= '0;
      skip_left_q   <= '0;
      neg_q         <= 1'b0;
      point_q       <= 1'b0;
      bad_q         <= 1'b0;
      started_q     <= 1'b0;
      int_q         <= '0;
      frac_q        <= '0;
      frac_digits_q <= '0;
      ovf_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      heading_q     <= '0;
      well_q        <= 1'b0;
      sat_q         <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      tag_pos_q     <= tag_pos_d;
      commas_left_q <= commas_left_d;
      skip_left_q   <= skip_left_d;
      neg_q         <= neg_d;
      point_q       <= point_d;
      bad_q         <= bad_d;
      started_q     <= started_d;
      int_q         <= int_d;
      frac_q        <= frac_d;
      frac_digits_q <= frac_digits_d;
      ovf_q         <= ovf_d;
      out_valid_q   <= out_valid_d;
      if (produce && take) begin
        heading_q <= heading_d;
        well_q    <= well_d;
        sat_q     <= sat_d;
      end
    end
  end

  assign result_o.valid              = out_valid_q;
  assign result_o.heading_hundredths = heading_q;
  assign result_o.well_formed        = well_q;
  assign result_o.saturated          = sat_q;

endmodule

FILE: hdl/shp_checker.sv
// ----------------------------------------------------------------------------
// shp_checker
// Port-level checks of the heading field parser, bound to the top level.
// ----------------------------------------------------------------------------
module shp_checker #(
  parameter int unsigned ValueWidth = shp_pkg::ValueWidthDefault
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [ValueWidth-1:0] heading_i,
  input logic                  well_formed_i,
  input logic                  saturated_i
);

  localparam logic [ValueWidth-1:0] MaxValue = {1'b0, {(ValueWidth-1){1'b1}}};
  localparam logic [ValueWidth-1:0] MinValue = {1'b1, {(ValueWidth-1){1'b0}}};

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(heading_i)
      && $stable(well_formed_i) && $stable(saturated_i))
    else $error("stalled result changed");

  // a malformed field reports zero without saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !well_formed_i |-> (heading_i == '0) && !saturated_i)
    else $error("malformed field with nonzero result");

  // clamped values sit at a range limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |->
      well_formed_i && ((heading_i == MaxValue) || (heading_i == MinValue)))
    else $error("saturated value not at a limit");

  // input back-pressure only comes from a stalled full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

endmodule

bind sensor_heading_field_parser_core shp_checker #(
  .ValueWidth (ValueWidth)
) u_shp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (data_i.valid),
  .in_ready_i    (data_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .heading_i     (result_o.heading_hundredths),
  .well_formed_i (result_o.well_formed),
  .saturated_i   (result_o.saturated)
);
